// ===== hdl/crcf_pkg.sv =====
package crcf_pkg;

    localparam int WORD_W = 64;
    localparam int IDX_W  = 5;
    localparam int LEN_W  = 6;

    localparam logic [LEN_W-1:0] CHAIN_LEN_RST = LEN_W'(32);

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
    } t_cand;

    // lower lane wins ties; the higher one only replaces on strictly smaller
    function automatic t_cand pick_min(input t_cand a, input t_cand b);
        t_cand res;
        res = a;
        if (b.ok && (b.val < a.val)) begin
            res = b;
        end
        return res;
    endfunction

endpackage

// ===== hdl/crcf_expand.sv =====
module crcf_expand import crcf_pkg::*; #(
    parameter int MAX_SITES = 32,
    parameter int LANES     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [LEN_W-1:0]     i_chain_length,
    input  logic [WORD_W-1:0]    i_state_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_cand                o_lane [LANES],
    output logic [MAX_SITES-1:0] o_match,
    output logic [LEN_W-1:0]     o_len
);

    logic                   r_s1_vld;
    logic [2*WORD_W-1:0]    r_s1_dbl;
    logic [WORD_W-1:0]      r_s1_mask;
    logic [LEN_W-1:0]       r_s1_len;

    logic                   r_s2_vld;
    t_cand                  r_s2_lane [LANES];
    logic [MAX_SITES-1:0]   r_s2_match;
    logic [LEN_W-1:0]       r_s2_len;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W:0]         sh_amt;
    logic [WORD_W-1:0]      n_s1_mask;
    logic [WORD_W-1:0]      masked;
    logic [2*WORD_W-1:0]    n_s1_dbl;
    t_cand                  n_s2_lane [LANES];
    logic [MAX_SITES-1:0]   n_s2_match;
    logic                   s1_rdy;
    logic                   s2_rdy;

    // stage 1: clamp length, mask unused sites, lay word twice end to end
    always_comb begin
        if (i_chain_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_chain_length > LEN_W'(MAX_SITES)) begin
            eff_len = LEN_W'(MAX_SITES);
        end else begin
            eff_len = i_chain_length;
        end
        sh_amt    = {eff_len, 1'b0};
        n_s1_mask = ~({WORD_W{1'b1}} << sh_amt);
        masked    = i_state_word & n_s1_mask;
        n_s1_dbl  = {{WORD_W{1'b0}}, masked} | ({{WORD_W{1'b0}}, masked} << sh_amt);
    end

    // stage 2: every rotation is a fixed window of the doubled word
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_s2_lane[k].val = r_s1_dbl[2*k +: WORD_W] & r_s1_mask;
            n_s2_lane[k].idx = IDX_W'(k);
            n_s2_lane[k].ok  = (LEN_W'(k) < r_s1_len);
        end
        for (int k = 0; k < MAX_SITES; k++) begin
            n_s2_match[k] = (k != 0) && (LEN_W'(k) < r_s1_len)
                            && (n_s2_lane[k].val == n_s2_lane[0].val);
        end
    end

    assign s2_rdy  = !r_s2_vld || i_ready;
    assign s1_rdy  = !r_s1_vld || s2_rdy;
    assign o_ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_valid;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_dbl  <= n_s1_dbl;
            r_s1_mask <= n_s1_mask;
            r_s1_len  <= eff_len;
        end
        if (s2_rdy) begin
            r_s2_lane  <= n_s2_lane;
            r_s2_match <= n_s2_match;
            r_s2_len   <= r_s1_len;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_lane  = r_s2_lane;
    assign o_match = r_s2_match;
    assign o_len   = r_s2_len;

endmodule

// ===== hdl/crcf_min_tree.sv =====
module crcf_min_tree import crcf_pkg::*; #(
    parameter int MAX_SITES = 32,
    parameter int LANES     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_cand                i_lane [LANES],
    input  logic [MAX_SITES-1:0] i_match,
    input  logic [LEN_W-1:0]     i_len,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_cand                o_cand,
    output logic [LEN_W-1:0]     o_period
);

    localparam int LVL = $clog2(LANES);

    // heap layout: node i has children 2i and 2i+1, leaves sit at LANES..2*LANES-1
    t_cand              r_node [1:LANES-1];
    t_cand              n_node [1:LANES-1];
    logic [LVL-1:0]     r_vld;
    logic [LEN_W-1:0]   r_per [LVL];
    logic [LEN_W-1:0]   n_per;
    logic [LVL-1:0]     lvl_rdy;

    always_comb begin
        for (int i = 1; i < LANES; i++) begin
            if (i >= LANES / 2) begin
                n_node[i] = pick_min(i_lane[2*i - LANES], i_lane[2*i + 1 - LANES]);
            end else begin
                n_node[i] = pick_min(r_node[2*i], r_node[2*i + 1]);
            end
        end
    end

    // first restoring rotation, full length if none earlier
    always_comb begin
        n_per = i_len;
        for (int k = MAX_SITES - 1; k > 0; k--) begin
            if (i_match[k]) begin
                n_per = LEN_W'(k);
            end
        end
    end

    always_comb begin
        lvl_rdy[LVL-1] = !r_vld[LVL-1] || !i_stall;
        for (int l = LVL - 2; l >= 0; l--) begin
            lvl_rdy[l] = !r_vld[l] || lvl_rdy[l+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (lvl_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int l = 1; l < LVL; l++) begin
                if (lvl_rdy[l]) begin
                    r_vld[l] <= r_vld[l-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_rdy[0]) begin
            r_per[0] <= n_per;
        end
        for (int l = 1; l < LVL; l++) begin
            if (lvl_rdy[l]) begin
                r_per[l] <= r_per[l-1];
            end
        end
    end

    for (genvar i = 1; i < LANES; i++) begin : g_node
        localparam int LV = LVL - $clog2(i + 1);
        always_ff @(posedge i_clk) begin
            if (lvl_rdy[LV]) begin
                r_node[i] <= n_node[i];
            end
        end
    end

    assign o_ready  = lvl_rdy[0];
    assign o_valid  = r_vld[LVL-1];
    assign o_cand   = r_node[1];
    assign o_period = r_per[LVL-1];

endmodule

// ===== hdl/cyclic_rotation_canonical_form.sv =====
// channel | direction | handshake              | payload
// input   | in        | i_valid / o_stall      | i_state_word
// result  | out       | o_valid / i_stall      | o_canonical_state, o_shift_count, o_period
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (chain_length)
//
// One item per cycle while the result side does not stall. Pipeline stages, in order:
// mask stage, rotation/compare stage, then each registered level of the min tree.
// Synchronous active-low reset clears all valid bits and sets chain_length to 32.
// A stall on the result side holds the last stage; bubbles further up still fill.
// Config is always ready and takes effect for items accepted after the write.
module cyclic_rotation_canonical_form import crcf_pkg::*; #(
    parameter int MAX_SITES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [WORD_W-1:0] i_state_word,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_canonical_state,
    output logic [IDX_W-1:0]  o_shift_count,
    output logic [LEN_W-1:0]  o_period,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    localparam int LANES = 1 << $clog2(MAX_SITES);

    logic [LEN_W-1:0]     r_chain_length;
    logic                 in_rdy;
    logic                 x_valid;
    logic                 x_ready;
    t_cand                x_lane [LANES];
    logic [MAX_SITES-1:0] x_match;
    logic [LEN_W-1:0]     x_len;
    t_cand                best;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_length <= CHAIN_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_chain_length <= i_cfg_data;
        end
    end

    crcf_expand #(
        .MAX_SITES (MAX_SITES),
        .LANES     (LANES)
    ) u_expand (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (in_rdy),
        .i_chain_length (r_chain_length),
        .i_state_word   (i_state_word),
        .o_valid        (x_valid),
        .i_ready        (x_ready),
        .o_lane         (x_lane),
        .o_match        (x_match),
        .o_len          (x_len)
    );

    crcf_min_tree #(
        .MAX_SITES (MAX_SITES),
        .LANES     (LANES)
    ) u_min_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (x_valid),
        .o_ready  (x_ready),
        .i_lane   (x_lane),
        .i_match  (x_match),
        .i_len    (x_len),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cand   (best),
        .o_period (o_period)
    );

    assign o_stall           = !in_rdy;
    assign o_canonical_state = best.val;
    assign o_shift_count     = best.idx;

`ifndef SYNTHESIS
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_period != '0) && (o_period <= LEN_W'(MAX_SITES)))
        else $error("period out of range");

    a_shift_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_shift_count} < o_period))
        else $error("shift count not below period");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output stage");

    a_best_winner_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> best.ok)
        else $error("result taken from an unused lane");
`endif

endmodule
